### rtl/ctsc_pkg.sv
package ctsc_pkg;

   // Robot mode codes as carried in the result
   typedef enum logic [2:0] {
      MODE_UNKNOWN    = 3'd0,
      MODE_SEEK_RED   = 3'd1,
      MODE_RED_LOCK   = 3'd2,
      MODE_SEEK_GREEN = 3'd3,
      MODE_GREEN_LOCK = 3'd4
   } mode_type;

   // Configuration register indexes
   localparam int unsigned CsrIndexWidth = 3;
   typedef logic [CsrIndexWidth-1:0] csr_index_type;

   localparam csr_index_type CSR_DETECT_THRESHOLD    = 3'd0;
   localparam csr_index_type CSR_ANGLE_THRESHOLD     = 3'd1;
   localparam csr_index_type CSR_TOO_CLOSE_THRESHOLD = 3'd2;
   localparam csr_index_type CSR_FORWARD_SPEED       = 3'd3;
   localparam csr_index_type CSR_BACKWARD_SPEED      = 3'd4;

   // Register reset values
   localparam logic [15:0]        DetectThresholdReset   = 16'd6554;
   localparam logic [14:0]        AngleThresholdReset    = 15'd2048;
   localparam logic [15:0]        TooCloseThresholdReset = 16'd32768;
   localparam logic signed [15:0] ForwardSpeedReset      = 16'sd8192;
   localparam logic signed [15:0] BackwardSpeedReset     = -16'sd8192;

   // Reciprocal of ten for a 16 bit magnitude: q = (m * 52429) >> 19
   localparam logic [16:0] RecipTen      = 17'd52429;
   localparam int unsigned RecipTenShift = 19;

   typedef struct packed {
      logic [15:0]        detect_threshold;
      logic [14:0]        angle_threshold;
      logic [15:0]        too_close_threshold;
      logic signed [15:0] forward_speed;
      logic signed [15:0] backward_speed;
   } cfg_type;

   typedef struct packed {
      logic [15:0]        red_strength;
      logic [15:0]        green_strength;
      logic signed [15:0] red_azimuth;
      logic signed [15:0] green_azimuth;
   } req_type;

   typedef struct packed {
      logic signed [15:0] left_drive;
      logic signed [15:0] right_drive;
      logic [2:0]         robot_mode;
   } rsp_type;

endpackage

### rtl/ctsc_csr.sv
module ctsc_csr (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  ctsc_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata,
   output ctsc_pkg::cfg_type       cfg
);
   import ctsc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // Decode the write; drop indexes beyond the register list
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_DETECT_THRESHOLD:    cfg_in.detect_threshold    = csr_wdata;
            CSR_ANGLE_THRESHOLD:     cfg_in.angle_threshold     = csr_wdata[14:0];
            CSR_TOO_CLOSE_THRESHOLD: cfg_in.too_close_threshold = csr_wdata;
            CSR_FORWARD_SPEED:       cfg_in.forward_speed       = csr_wdata;
            CSR_BACKWARD_SPEED:      cfg_in.backward_speed      = csr_wdata;
            default:                 cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.detect_threshold    <= DetectThresholdReset;
         cfg_ff.angle_threshold     <= AngleThresholdReset;
         cfg_ff.too_close_threshold <= TooCloseThresholdReset;
         cfg_ff.forward_speed       <= ForwardSpeedReset;
         cfg_ff.backward_speed      <= BackwardSpeedReset;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

### rtl/ctsc_steer.sv
module ctsc_steer (
   input  logic              clock,
   input  logic              reset,
   input  ctsc_pkg::cfg_type cfg,
   input  ctsc_pkg::req_type item,
   input  logic              fire,
   output ctsc_pkg::rsp_type result
);
   import ctsc_pkg::*;

   mode_type           mode_ff;
   mode_type           mode_in;
   logic signed [15:0] acc_ff;
   logic signed [15:0] acc_in;

   logic               unknown;
   logic               red_wins;
   logic signed [15:0] err;
   logic [15:0]        err_mag;
   logic               locked;
   logic signed [15:0] acc_keep;
   logic signed [15:0] acc_seek;
   logic               disagree;
   logic signed [17:0] sum;
   logic signed [17:0] neg_sum;
   logic [32:0]        prod;
   logic [13:0]        quot_mag;
   logic signed [15:0] quot;
   logic signed [17:0] acc_sum;

   // Clamp an 18 bit signed value to the 16 bit signed range
   function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
      logic signed [15:0] r;
      if (v > 18'sd32767) begin
         r = 16'sh7FFF;
      end else if (v < -18'sd32768) begin
         r = 16'sh8000;
      end else begin
         r = v[15:0];
      end
      return r;
   endfunction

   // Pick the winning colour and its error
   assign unknown  = (item.red_strength < cfg.detect_threshold) &&
                     (item.green_strength < cfg.detect_threshold);
   assign red_wins = item.red_strength > item.green_strength;
   assign err      = red_wins ? item.red_azimuth : item.green_azimuth;
   assign err_mag  = err[15] ? 16'(-err) : 16'(err);
   assign locked   = err_mag < {1'b0, cfg.angle_threshold};

   always_comb begin
      priority if (unknown) begin
         mode_in = MODE_UNKNOWN;
      end else if (red_wins) begin
         mode_in = locked ? MODE_RED_LOCK : MODE_SEEK_RED;
      end else begin
         mode_in = locked ? MODE_GREEN_LOCK : MODE_SEEK_GREEN;
      end
   end

   // Clear the accumulator on a mode change or a sign disagreement
   assign acc_keep = (mode_in != mode_ff) ? 16'sd0 : acc_ff;
   assign disagree = (err[15] && (acc_keep > 16'sd0)) ||
                     ((err > 16'sd0) && acc_keep[15]);
   assign acc_seek = disagree ? 16'sd0 : acc_keep;

   // Differential steering sum
   assign sum     = {{2{err[15]}}, err} + {{2{acc_seek[15]}}, acc_seek};
   assign neg_sum = -sum;

   // Divide the error by ten, truncating toward zero
   assign prod     = {1'b0, err_mag} * {16'd0, RecipTen};
   assign quot_mag = prod[RecipTenShift +: 14];
   assign quot     = err[15] ? -$signed({2'b00, quot_mag}) : $signed({2'b00, quot_mag});
   assign acc_sum  = {{2{acc_seek[15]}}, acc_seek} + {{2{quot[15]}}, quot};

   // Form the wheel commands and the next accumulator
   always_comb begin
      result.robot_mode  = mode_in;
      result.left_drive  = 16'sd0;
      result.right_drive = 16'sd0;
      acc_in             = acc_keep;
      unique case (mode_in)
         MODE_UNKNOWN: begin
            acc_in = acc_keep;
         end
         MODE_RED_LOCK: begin
            result.left_drive  = cfg.backward_speed;
            result.right_drive = cfg.backward_speed;
         end
         MODE_GREEN_LOCK: begin
            if (item.green_strength <= cfg.too_close_threshold) begin
               result.left_drive  = cfg.forward_speed;
               result.right_drive = cfg.forward_speed;
            end
         end
         MODE_SEEK_RED, MODE_SEEK_GREEN: begin
            result.left_drive  = sat16(sum);
            result.right_drive = sat16(neg_sum);
            acc_in             = sat16(acc_sum);
         end
         default: begin
            acc_in = acc_keep;
         end
      endcase
   end

   // Advance the state once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_UNKNOWN;
         acc_ff  <= 16'sd0;
      end else if (fire) begin
         mode_ff <= mode_in;
         acc_ff  <= acc_in;
      end
   end

endmodule

### rtl/color_target_steering_controller.sv
// A request is registered in the input stage and its result in the output stage,
// which drives rsp_valid; an output stage that is full and not taken stalls both.
// Throughput: one transaction per cycle while rsp_ready holds; the mode and
// steering accumulator update in the same cycle as the compute stage, so the next
// request sees them. Reset: synchronous, active high; empties both stages, sets
// mode to unknown, clears the accumulator and loads the register reset values.
module color_target_steering_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  ctsc_pkg::req_type       req_data,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output ctsc_pkg::rsp_type       rsp_data,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  ctsc_pkg::csr_index_type csr_index,
   input  logic [15:0]             csr_wdata
);
   import ctsc_pkg::*;

   cfg_type cfg;
   logic    in_valid_ff;
   req_type in_data_ff;
   logic    out_valid_ff;
   rsp_type out_data_ff;
   rsp_type result;
   logic    advance;

   ctsc_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ctsc_steer u_steer (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .item   (in_data_ff),
      .fire   (advance),
      .result (result)
   );

   // Move the input stage forward when the output stage is free or draining
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // Input stage
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_ready) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_data_ff <= req_data;
      end
   end

   // Output stage: hold until taken
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_data_ff <= result;
      end
   end

endmodule

### rtl/ctsc_checker.sv
module ctsc_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input ctsc_pkg::rsp_type rsp_data
);
   import ctsc_pkg::*;

   // Hold a stalled response
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // Stand still in unknown mode
   a_unknown_stop: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.robot_mode == MODE_UNKNOWN) |->
         (rsp_data.left_drive == 16'sd0) && (rsp_data.right_drive == 16'sd0))
      else $error("drive nonzero in unknown mode");

   // Drive both wheels alike when locked
   a_lock_straight: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_data.robot_mode == MODE_RED_LOCK) ||
                    (rsp_data.robot_mode == MODE_GREEN_LOCK)) |->
         rsp_data.left_drive == rsp_data.right_drive)
      else $error("wheels differ in a locked mode");

   // Drop any response on reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind color_target_steering_controller ctsc_checker u_ctsc_checker (.*);

### verif/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ctsc_pkg::*;

   typedef enum int {
      RX_ALWAYS,
      RX_HALF,
      RX_MOSTLY,
      RX_PERIODIC
   } rx_style_type;

   localparam int SteerDivisor = 10;
   localparam int LatencyCycles = 2;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [15:0]   csr_wdata;

   // Predictor state: register copy, mode and steering accumulator
   cfg_type            cfg_shadow = '{
      detect_threshold:    DetectThresholdReset,
      angle_threshold:     AngleThresholdReset,
      too_close_threshold: TooCloseThresholdReset,
      forward_speed:       ForwardSpeedReset,
      backward_speed:      BackwardSpeedReset
   };
   mode_type           mode_shadow = MODE_UNKNOWN;
   logic signed [15:0] steer_shadow = '0;

   rsp_type drive_expect[$];

   // Traffic shaping
   rx_style_type rx_style = RX_ALWAYS;
   int           hold_left = 0;
   int           rx_cycle = 0;
   bit           send_gaps = 1'b1;
   int           burst_left = 0;

   // Seek run state for the random generator
   int seek_left = 0;
   bit seek_red;
   bit seek_neg;
   bit seek_big;

   // Bookkeeping
   int error_count = 0;
   int frames_sent = 0;
   int results_checked = 0;
   int csr_writes = 0;
   int req_stall_cycles = 0;
   int mode_hits[5] = '{default: 0};

   color_target_steering_controller i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Bound the run
   initial begin
      #200000;
      $display("TB_ERROR");
      $finish;
   end

   // Clamp to the 16 bit signed range
   function automatic logic signed [15:0] clip16(input int value);
      if (value > 32767) return 16'sh7fff;
      if (value < -32768) return 16'sh8000;
      return value[15:0];
   endfunction

   // Compute the wheel commands for one frame and advance the predictor state
   function automatic rsp_type predict_drive(input req_type frame);
      rsp_type  drive;
      mode_type next_mode;
      int       red_az;
      int       green_az;
      int       err;
      int       sum;
      int       acc;
      red_az = int'($signed(frame.red_azimuth));
      green_az = int'($signed(frame.green_azimuth));
      if (frame.red_strength < cfg_shadow.detect_threshold &&
          frame.green_strength < cfg_shadow.detect_threshold)
         next_mode = MODE_UNKNOWN;
      else if (frame.red_strength > frame.green_strength)
         next_mode = ((red_az < 0 ? -red_az : red_az) < int'(cfg_shadow.angle_threshold)) ?
                     MODE_RED_LOCK : MODE_SEEK_RED;
      else
         next_mode = ((green_az < 0 ? -green_az : green_az) <
                      int'(cfg_shadow.angle_threshold)) ? MODE_GREEN_LOCK : MODE_SEEK_GREEN;

      acc = int'(steer_shadow);
      if (next_mode != mode_shadow) acc = 0;
      mode_shadow = next_mode;
      mode_hits[int'(next_mode)]++;

      drive.left_drive = '0;
      drive.right_drive = '0;
      drive.robot_mode = next_mode;
      case (next_mode)
         MODE_RED_LOCK: begin
            drive.left_drive = cfg_shadow.backward_speed;
            drive.right_drive = cfg_shadow.backward_speed;
         end
         MODE_GREEN_LOCK: begin
            if (frame.green_strength <= cfg_shadow.too_close_threshold) begin
               drive.left_drive = cfg_shadow.forward_speed;
               drive.right_drive = cfg_shadow.forward_speed;
            end
         end
         MODE_SEEK_RED, MODE_SEEK_GREEN: begin
            err = (next_mode == MODE_SEEK_RED) ? red_az : green_az;
            // Drop the integral when it disagrees in sign with the error
            if ((err < 0 && acc > 0) || (err > 0 && acc < 0)) acc = 0;
            sum = err + acc;
            drive.left_drive = clip16(sum);
            drive.right_drive = clip16(-sum);
            acc = int'(clip16(acc + err / SteerDivisor));
         end
         default: ;
      endcase
      steer_shadow = acc[15:0];
      return drive;
   endfunction

   function automatic req_type make_frame(input int red, input int green,
                                          input int red_az, input int green_az);
      req_type frame;
      frame.red_strength = red[15:0];
      frame.green_strength = green[15:0];
      frame.red_azimuth = red_az[15:0];
      frame.green_azimuth = green_az[15:0];
      return frame;
   endfunction

   // Strength within one step of a threshold, clamped to the field range
   function automatic logic [15:0] near_strength(input int center);
      int value;
      value = center + $urandom_range(0, 2) - 1;
      if (value < 0) value = 0;
      if (value > 65535) value = 65535;
      return value[15:0];
   endfunction

   // Azimuth on or next to the lock boundary, at zero, or at full scale
   function automatic logic [15:0] edge_azimuth();
      int value;
      case ($urandom_range(0, 5))
         0: value = -32768;
         1: value = 32767;
         2: value = 0;
         default: value = int'(cfg_shadow.angle_threshold) + $urandom_range(0, 2) - 1;
      endcase
      if ($urandom_range(0, 1) == 1) value = -value;
      if (value > 32767) value = 32767;
      if (value < -32768) value = -32768;
      return value[15:0];
   endfunction

   // Build one random frame: mostly seek runs, some boundary cases, some noise
   function automatic req_type pick_frame();
      req_type frame;
      int      style;
      int      dom;
      int      other;
      int      lo;
      int      hi;
      int      mag;
      int      az;
      style = $urandom_range(0, 99);
      if (style < 15) begin
         frame = {$urandom, $urandom};
      end else if (style < 40) begin
         frame.red_strength = ($urandom_range(0, 3) == 0) ? 16'($urandom) :
                              near_strength(int'(cfg_shadow.detect_threshold));
         case ($urandom_range(0, 3))
            0: frame.green_strength = frame.red_strength;
            1: frame.green_strength = near_strength(int'(cfg_shadow.too_close_threshold));
            2: frame.green_strength = near_strength(int'(cfg_shadow.detect_threshold));
            default: frame.green_strength = 16'($urandom);
         endcase
         frame.red_azimuth = edge_azimuth();
         frame.green_azimuth = edge_azimuth();
      end else begin
         if (seek_left == 0) begin
            seek_left = $urandom_range(3, 30);
            seek_red = 1'($urandom_range(0, 1));
            seek_neg = 1'($urandom_range(0, 1));
            seek_big = 1'($urandom_range(0, 1));
         end
         seek_left--;
         // Flip the error sign now and then to clear the integral
         if ($urandom_range(0, 9) == 0) seek_neg = ~seek_neg;
         hi = seek_neg ? 32768 : 32767;
         lo = int'(cfg_shadow.angle_threshold);
         if (seek_big && hi - 4000 > lo) lo = hi - 4000;
         mag = $urandom_range(lo, hi);
         az = seek_neg ? -mag : mag;
         dom = $urandom_range((cfg_shadow.detect_threshold > 1) ?
                              int'(cfg_shadow.detect_threshold) : 1, 65535);
         other = $urandom_range(0, dom - 1);
         frame = {$urandom, $urandom};
         if (seek_red) begin
            frame.red_strength = dom[15:0];
            frame.green_strength = other[15:0];
            frame.red_azimuth = az[15:0];
         end else begin
            frame.green_strength = dom[15:0];
            frame.red_strength = other[15:0];
            frame.green_azimuth = az[15:0];
         end
      end
      return frame;
   endfunction

   // Offer one frame, hold it until accepted, then record its expected result
   task automatic send_frame(input req_type frame);
      int gap;
      if (send_gaps && burst_left == 0) begin
         gap = $urandom_range(1, 12);
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid = 1'b1;
      req_data = frame;
      forever begin
         @(posedge clock);
         if (req_ready) break;
         req_stall_cycles++;
      end
      drive_expect.push_back(predict_drive(frame));
      frames_sent++;
      @(negedge clock);
      req_valid = 1'b0;
   endtask

   task automatic run_random(input int count);
      repeat (count) send_frame(pick_frame());
   endtask

   // Wait for every pending result, then let the pipeline drain
   task automatic wait_idle();
      while (drive_expect.size() != 0) @(negedge clock);
      repeat (LatencyCycles + 2) @(negedge clock);
   endtask

   task automatic write_reg(input csr_index_type index, input logic [15:0] value);
      csr_valid = 1'b1;
      csr_index = index;
      csr_wdata = value;
      do @(posedge clock); while (!csr_ready);
      case (index)
         CSR_DETECT_THRESHOLD:    cfg_shadow.detect_threshold = value;
         CSR_ANGLE_THRESHOLD:     cfg_shadow.angle_threshold = value[14:0];
         CSR_TOO_CLOSE_THRESHOLD: cfg_shadow.too_close_threshold = value;
         CSR_FORWARD_SPEED:       cfg_shadow.forward_speed = value;
         CSR_BACKWARD_SPEED:      cfg_shadow.backward_speed = value;
         default: ;
      endcase
      csr_writes++;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic apply_settings(input logic [15:0] detect, input logic [14:0] angle,
                                 input logic [15:0] too_close, input logic [15:0] forward,
                                 input logic [15:0] backward);
      wait_idle();
      write_reg(CSR_DETECT_THRESHOLD, detect);
      write_reg(CSR_ANGLE_THRESHOLD, {1'b0, angle});
      write_reg(CSR_TOO_CLOSE_THRESHOLD, too_close);
      write_reg(CSR_FORWARD_SPEED, forward);
      write_reg(CSR_BACKWARD_SPEED, backward);
   endtask

   task automatic report_error(input string what, input rsp_type want, input rsp_type got);
      error_count++;
      if (error_count <= 10)
         $display("%s: expected left %0d right %0d mode %0d, got left %0d right %0d mode %0d",
                  what, $signed(want.left_drive), $signed(want.right_drive), want.robot_mode,
                  $signed(got.left_drive), $signed(got.right_drive), got.robot_mode);
   endtask

   // Receiver: stall on the selected pattern, or hold off for a counted stretch
   initial begin
      rsp_ready = 1'b0;
      forever begin
         @(negedge clock);
         rx_cycle++;
         if (hold_left > 0) begin
            rsp_ready = 1'b0;
            hold_left--;
         end else begin
            case (rx_style)
               RX_ALWAYS:   rsp_ready = 1'b1;
               RX_HALF:     rsp_ready = 1'($urandom_range(0, 1));
               RX_MOSTLY:   rsp_ready = ($urandom_range(0, 3) != 0);
               default:     rsp_ready = (rx_cycle % 7) < 4;
            endcase
         end
      end
   end

   // Compare each result transaction with the oldest prediction
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (drive_expect.size() == 0) begin
            report_error("unexpected result", '0, rsp_data);
         end else begin
            want = drive_expect.pop_front();
            results_checked++;
            if (want.left_drive !== rsp_data.left_drive ||
                want.right_drive !== rsp_data.right_drive ||
                want.robot_mode !== rsp_data.robot_mode)
               report_error("mismatch", want, rsp_data);
         end
      end
   end

   // Boundary frames at the reset register values
   task automatic test_directed_cases();
      rx_style = RX_MOSTLY;
      send_frame(make_frame(0, 0, 0, 0));
      // tie at full strength goes to green, far off axis
      send_frame(make_frame(65535, 65535, -32768, 32767));
      send_frame(make_frame(6553, 6553, 0, 0));
      send_frame(make_frame(6554, 0, 0, 0));
      send_frame(make_frame(6554, 6554, 0, 2047));
      send_frame(make_frame(0, 32768, 0, -2047));
      send_frame(make_frame(0, 32769, 0, 0));
      send_frame(make_frame(0, 65535, 0, 2048));
      // drive the integral into negative saturation
      repeat (12) send_frame(make_frame(0, 20000, 0, -32768));
      send_frame(make_frame(0, 20000, 0, 32767));
      // small negative errors truncate toward zero
      send_frame(make_frame(0, 20000, 0, -15));
      send_frame(make_frame(0, 20000, 0, -15));
      send_frame(make_frame(65535, 65534, 32767, 0));
      send_frame(make_frame(65535, 65534, -32768, 0));
      send_frame(make_frame(65535, 0, -2048, 0));
      send_frame(make_frame(65535, 0, -2047, 0));
   endtask

   task automatic test_default_traffic();
      rx_style = RX_HALF;
      run_random(100);
   endtask

   // Register extremes: always seeking, mostly unknown, and mostly locked
   task automatic test_threshold_extremes();
      apply_settings(16'd0, 15'd0, 16'd65535, 16'h7fff, 16'h8000);
      rx_style = RX_PERIODIC;
      send_frame(make_frame(0, 0, 0, 0));
      run_random(100);

      apply_settings(16'd65535, 15'd32767, 16'd0, 16'h8000, 16'h7fff);
      rx_style = RX_HALF;
      // full scale negative azimuth never locks
      send_frame(make_frame(0, 65535, 0, -32768));
      send_frame(make_frame(0, 65535, 0, 32766));
      send_frame(make_frame(65535, 0, -32767, 0));
      run_random(100);

      apply_settings(16'd0, 15'd32767, 16'd65535, 16'h8000, 16'h7fff);
      rx_style = RX_ALWAYS;
      send_gaps = 1'b0;
      send_frame(make_frame(0, 65535, 0, 32766));
      run_random(100);
      send_gaps = 1'b1;
   endtask

   task automatic test_random_settings();
      repeat (3) begin
         apply_settings(16'($urandom_range(0, 20000)), 15'($urandom_range(0, 8000)),
                        16'($urandom), 16'($urandom), 16'($urandom));
         rx_style = rx_style_type'($urandom_range(0, 3));
         send_gaps = 1'($urandom_range(0, 1));
         run_random(120);
      end
      send_gaps = 1'b1;
   endtask

   // Hold the receiver off while the sender keeps offering frames
   task automatic test_backpressure();
      wait_idle();
      rx_style = RX_HALF;
      send_gaps = 1'b0;
      hold_left = 300;
      run_random(80);
      send_gaps = 1'b1;
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      csr_valid = 1'b0;
      csr_index = CSR_DETECT_THRESHOLD;
      csr_wdata = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed_cases();
      test_default_traffic();
      test_threshold_extremes();
      test_random_settings();
      test_backpressure();

      wait_idle();
      repeat (8) @(negedge clock);
      $display("Checked %0d drive results from %0d frames, %0d register writes, %0d input stalls",
               results_checked, frames_sent, csr_writes, req_stall_cycles);
      $display("Modes: unknown %0d, seek red %0d, red lock %0d, seek green %0d, green lock %0d",
               mode_hits[0], mode_hits[1], mode_hits[2], mode_hits[3], mode_hits[4]);
      if (error_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

endmodule

### files.f
rtl/ctsc_pkg.sv
rtl/ctsc_csr.sv
rtl/ctsc_steer.sv
rtl/color_target_steering_controller.sv
rtl/ctsc_checker.sv
verif/tb.sv
